// ===== rtl/core/mbmk_pkg.sv =====
// ----------------------------------------------------------------------------
// mbmk_pkg
// Shared constants, region codes and decode record for the bus memory map.
// ----------------------------------------------------------------------------
package mbmk_pkg;

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int KEY_W      = 64;
   localparam int KEY_ROWS   = 8;
   localparam int KEY_COLS   = 8;
   localparam int ROM_OFF_W  = 13;
   localparam int CELL_W     = 5;
   localparam int CELL_COLS  = 24;

   localparam int RAM_BYTES   = 8192;
   localparam int VIDEO_BYTES = 1024;
   localparam int RAM_AW      = $clog2(RAM_BYTES);
   localparam int VID_AW      = $clog2(VIDEO_BYTES);

   localparam logic [ADDR_W-1:0] VIDEO_BASE   = 16'hD000;
   localparam logic [ADDR_W-1:0] KBD_BASE     = 16'hDF00;
   localparam logic [ADDR_W-1:0] KBD_LAST     = 16'hDFFF;
   localparam logic [ADDR_W-1:0] BASIC_BASE   = 16'hA000;
   localparam logic [ADDR_W-1:0] MONITOR_BASE = 16'hF800;
   localparam logic [ADDR_W-1:0] WINDOW_FIRST = 16'hD085;
   localparam logic [ADDR_W-1:0] WINDOW_LAST  = 16'hD37C;

   // region bounds one bit wider so that the end of the 64k space fits
   localparam logic [ADDR_W:0] RAM_END   = (ADDR_W+1)'(RAM_BYTES);
   localparam logic [ADDR_W:0] VIDEO_END = (ADDR_W+1)'(VIDEO_BASE) + (ADDR_W+1)'(VIDEO_BYTES);
   localparam logic [ADDR_W:0] KBD_END   = 17'h0E000;
   localparam logic [ADDR_W:0] BASIC_END = 17'h0C000;

   localparam logic [DATA_W-1:0] KBD_IDLE = 8'hFF;

   typedef enum logic [2:0] {
      REG_RAM      = 3'd0,
      REG_VIDEO    = 3'd1,
      REG_KBD      = 3'd2,
      REG_BASIC    = 3'd3,
      REG_MONITOR  = 3'd4,
      REG_UNMAPPED = 3'd5
   } region_type;

   typedef struct packed {
      region_type             region;
      logic                   ram_we;
      logic                   vid_we;
      logic                   latch_we;
      logic                   ram_rd;
      logic                   vid_rd;
      logic [DATA_W-1:0]      kbd_data;
      logic [ROM_OFF_W-1:0]   rom_offset;
      logic                   paint_valid;
      logic [CELL_W-1:0]      cell_x;
      logic [CELL_W-1:0]      cell_y;
   } decode_type;

endpackage

// ===== rtl/core/mbmk_ram.sv =====
// ----------------------------------------------------------------------------
// mbmk_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mbmk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/mbmk_decode.sv =====
// ----------------------------------------------------------------------------
// mbmk_decode
// Address decode, keyboard column scan and screen cell calculation.
// ----------------------------------------------------------------------------
module mbmk_decode (
   input  logic                          mode,
   input  logic [mbmk_pkg::ADDR_W-1:0]   address,
   input  logic [mbmk_pkg::KEY_W-1:0]    key_matrix,
   input  logic [mbmk_pkg::DATA_W-1:0]   row_select,
   output mbmk_pkg::decode_type          dec
);
   import mbmk_pkg::*;

   logic [ADDR_W:0]     addr_ext;
   logic [ADDR_W-1:0]   win_off;
   logic [KEY_COLS-1:0] col_hit;
   logic                in_window;

   assign addr_ext = {1'b0, address};
   assign win_off  = address - WINDOW_FIRST;
   assign in_window = (address >= WINDOW_FIRST) && (address <= WINDOW_LAST)
                      && (win_off[4:0] < CELL_W'(CELL_COLS));

   // row r is scanned while latch bit 7-r is low; a key clears bit 7-c
   always_comb begin
      col_hit = '0;
      for (int r = 0; r < KEY_ROWS; r++) begin
         if (!row_select[KEY_ROWS-1-r]) begin
            col_hit = col_hit | key_matrix[r*KEY_COLS +: KEY_COLS];
         end
      end
   end

   always_comb begin
      dec        = '0;
      dec.region = REG_UNMAPPED;
      priority if (addr_ext < RAM_END) begin
         dec.region = REG_RAM;
         dec.ram_we = mode;
         dec.ram_rd = !mode;
      end else if (address >= VIDEO_BASE && addr_ext < VIDEO_END) begin
         dec.region = REG_VIDEO;
         dec.vid_we = mode;
         dec.vid_rd = !mode;
         if (mode && in_window) begin
            dec.paint_valid = 1'b1;
            dec.cell_x      = win_off[4:0];
            dec.cell_y      = win_off[9:5];
         end
      end else if (address >= KBD_BASE && addr_ext < KBD_END) begin
         dec.region   = REG_KBD;
         dec.latch_we = mode && (address != KBD_LAST);
         if (!mode) begin
            for (int c = 0; c < KEY_COLS; c++) begin
               dec.kbd_data[KEY_COLS-1-c] = !col_hit[c];
            end
         end
      end else if (address >= BASIC_BASE && addr_ext < BASIC_END) begin
         dec.region = REG_BASIC;
         if (!mode) begin
            dec.rom_offset = ROM_OFF_W'(address - BASIC_BASE);
         end
      end else if (address >= MONITOR_BASE) begin
         dec.region = REG_MONITOR;
         if (!mode) begin
            dec.rom_offset = ROM_OFF_W'(address - MONITOR_BASE);
         end
      end else begin
         dec.region = REG_UNMAPPED;
      end
   end

endmodule

// ===== rtl/core/micro_bus_memory_map_with_keyboard_unit.sv =====
// ----------------------------------------------------------------------------
// micro_bus_memory_map_with_keyboard_unit
// Bus memory map: program RAM, video RAM, keyboard port, ROM address decode.
// ----------------------------------------------------------------------------
// One bus access is taken per cycle (start high, busy low) and its result
// appears on the rsp_ ports with rsp_strobe in the next cycle; the receiver
// cannot stall, so every result must be taken in that cycle. Like the read
// of the program and video RAMs, the result is registered. After reset busy
// stays high while a clearing pass over all RAM_BYTES (8192) addresses
// zeroes program RAM and video RAM, one address per cycle. A read may follow
// a write to the same location in the next cycle and sees the written byte.
// ----------------------------------------------------------------------------
module micro_bus_memory_map_with_keyboard_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic [mbmk_pkg::ADDR_W-1:0]      req_address,
   input  logic [mbmk_pkg::DATA_W-1:0]      req_write_data,
   input  logic [mbmk_pkg::KEY_W-1:0]       req_key_matrix,
   output logic                             rsp_strobe,
   output logic [2:0]                       rsp_region,
   output logic [mbmk_pkg::DATA_W-1:0]      rsp_read_data,
   output logic [mbmk_pkg::ROM_OFF_W-1:0]   rsp_rom_offset,
   output logic                             rsp_paint_valid,
   output logic [mbmk_pkg::CELL_W-1:0]      rsp_cell_x,
   output logic [mbmk_pkg::CELL_W-1:0]      rsp_cell_y
);
   import mbmk_pkg::*;

   decode_type dec;
   logic       accept;

   // clearing pass
   logic              clear_ff, clear_in;
   logic [RAM_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic              clr_last;

   logic [DATA_W-1:0] latch_ff, latch_in;

   // result stage
   logic                 strobe_ff, strobe_in;
   region_type           region_ff;
   logic                 ram_rd_ff, vid_rd_ff;
   logic [DATA_W-1:0]    kbd_ff;
   logic [ROM_OFF_W-1:0] rom_off_ff;
   logic                 paint_ff;
   logic [CELL_W-1:0]    cell_x_ff, cell_y_ff;

   // RAM ports
   logic              ram_we, vid_we;
   logic [RAM_AW-1:0] ram_addr;
   logic [VID_AW-1:0] vid_addr;
   logic [DATA_W-1:0] ram_wdata, ram_q, vid_q;

   assign busy   = clear_ff;
   assign accept = start && !clear_ff;

   mbmk_decode u_decode (
      .mode       (req_mode),
      .address    (req_address),
      .key_matrix (req_key_matrix),
      .row_select (latch_ff),
      .dec        (dec)
   );

   assign clr_last = (clr_cnt_ff == RAM_AW'(RAM_BYTES - 1));

   always_comb begin
      clear_in   = clear_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clear_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_last) begin
            clear_in = 1'b0;
         end
      end
   end

   always_comb begin
      latch_in = latch_ff;
      if (accept && dec.latch_we) begin
         latch_in = req_write_data;
      end
   end

   assign strobe_in = accept;

   always_comb begin
      if (clear_ff) begin
         ram_addr  = clr_cnt_ff;
         vid_addr  = clr_cnt_ff[VID_AW-1:0];
         ram_wdata = '0;
         ram_we    = 1'b1;
         vid_we    = ({1'b0, clr_cnt_ff} < (RAM_AW+1)'(VIDEO_BYTES));
      end else begin
         ram_addr  = req_address[RAM_AW-1:0];
         vid_addr  = VID_AW'(req_address - VIDEO_BASE);
         ram_wdata = req_write_data;
         ram_we    = accept && dec.ram_we;
         vid_we    = accept && dec.vid_we;
      end
   end

   mbmk_ram #(.WIDTH(DATA_W), .DEPTH(RAM_BYTES)) u_program_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_q)
   );

   mbmk_ram #(.WIDTH(DATA_W), .DEPTH(VIDEO_BYTES)) u_screen_ram (
      .clock (clock),
      .we    (vid_we),
      .addr  (vid_addr),
      .wdata (ram_wdata),
      .rdata (vid_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_cnt_ff <= '0;
         latch_ff   <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         clear_ff   <= clear_in;
         clr_cnt_ff <= clr_cnt_in;
         latch_ff   <= latch_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         region_ff  <= dec.region;
         ram_rd_ff  <= dec.ram_rd;
         vid_rd_ff  <= dec.vid_rd;
         kbd_ff     <= dec.kbd_data;
         rom_off_ff <= dec.rom_offset;
         paint_ff   <= dec.paint_valid;
         cell_x_ff  <= dec.cell_x;
         cell_y_ff  <= dec.cell_y;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_region      = region_ff;
   assign rsp_read_data   = ram_rd_ff ? ram_q : (vid_rd_ff ? vid_q : kbd_ff);
   assign rsp_rom_offset  = rom_off_ff;
   assign rsp_paint_valid = paint_ff;
   assign rsp_cell_x      = cell_x_ff;
   assign rsp_cell_y      = cell_y_ff;

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted request produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result without a request");

   a_paint_video: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_paint_valid) |-> (region_ff == REG_VIDEO && cell_x_ff < CELL_W'(CELL_COLS)))
      else $error("repaint outside video region or window");

   a_rom_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_rom_offset != '0) |->
         (region_ff == REG_BASIC || region_ff == REG_MONITOR))
      else $error("ROM offset on a non-ROM access");

   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |-> $past(clr_last))
      else $error("clearing pass ended early");

endmodule
